### rtl/dwg_pkg.sv
// Shared types, register codes and helpers of the damped wave grid step.
// Used by dwg_math and damped_wave_grid_step; depends on nothing.
package dwg_pkg;

  localparam int VAL_W      = 16;
  localparam int CFG_DATA_W = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int MIN_DIM    = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COEF_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_CENTRE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS   = 3'd5;

  // Register reset values
  localparam logic [14:0] COEF_X_RST      = 15'd409;
  localparam logic [14:0] COEF_Y_RST      = 15'd409;
  localparam logic [17:0] COEF_CENTRE_RST = 18'd129436;
  localparam logic [16:0] DAMPING_RST     = 17'd65405;
  localparam logic [7:0]  GRID_COLS_RST   = 8'd80;
  localparam logic [7:0]  GRID_ROWS_RST   = 8'd80;

  typedef struct packed {
    logic signed [15:0] cur_value;
    logic signed [15:0] old_value;
    logic               is_land;
    logic               is_flush;
    logic               frame_first;
  } dwg_in_t;

  typedef struct packed {
    logic signed [15:0] new_value;
    logic signed [15:0] damped_value;
    logic [6:0]         row;
    logic [6:0]         col;
    logic               last_of_frame;
  } dwg_out_t;

  typedef struct packed {
    logic [14:0] coef_x;
    logic [14:0] coef_y;
    logic [17:0] coef_centre;
    logic [16:0] damping;
  } dwg_coef_t;

  // Per-cell control that rides along the arithmetic pipeline
  typedef struct packed {
    logic       land;
    logic       interior;
    logic       last;
    logic [6:0] row;
    logic [6:0] col;
  } dwg_tag_t;

  typedef struct packed {
    logic signed [15:0] above;
    logic signed [15:0] below;
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic signed [15:0] centre;
    logic signed [15:0] old;
    dwg_tag_t           tag;
  } dwg_job_t;

  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    logic signed [15:0] r;
    if (v > 32'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -32'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

### rtl/dwg_cell.sv
// One stage of a variable-length delay chain: loads the line input when it is
// the entry point, otherwise takes its neighbor's word. No package needed.
module dwg_cell #(
  parameter int W = 16
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic         load_i,
  input  logic [W-1:0] line_i,
  input  logic [W-1:0] prev_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] data_q;
  logic [W-1:0] data_d;

  assign data_d = load_i ? line_i : prev_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign q_o = data_q;

endmodule

### rtl/dwg_line.sv
// Row delay built from a chain of dwg_cell stages; the entry stage sets the length.
// Depends on dwg_cell.
module dwg_line #(
  parameter int W     = 16,
  parameter int DEPTH = 128,
  parameter int SEL_W = 9
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [SEL_W-1:0] start_i,
  input  logic [W-1:0]     line_i,
  output logic [W-1:0]     line_o
);

  logic [W-1:0] tap [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [W-1:0] prev;
    if (k == 0) begin : g_head
      assign prev = line_i;
    end else begin : g_body
      assign prev = tap[k-1];
    end

    dwg_cell #(
      .W(W)
    ) u_cell (
      .clk_i (clk_i),
      .en_i  (en_i),
      .load_i(start_i == SEL_W'(k)),
      .line_i(line_i),
      .prev_i(prev),
      .q_o   (tap[k])
    );
  end

  // Last stage is the fixed output tap
  assign line_o = tap[DEPTH-1];

endmodule

### rtl/dwg_math.sv
// Five-stage stencil arithmetic: neighbor sums, weighting, damping, rounding
// and saturation. Depends on dwg_pkg.
module dwg_math (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               job_valid_i,
  input  dwg_pkg::dwg_job_t  job_i,
  input  dwg_pkg::dwg_coef_t coef_i,
  output logic               res_valid_o,
  output dwg_pkg::dwg_out_t  res_o
);

  logic [4:0] v_q;

  // stage 1
  logic signed [16:0] ns1_q, we1_q;
  logic signed [15:0] c1_q, old1_q;
  dwg_pkg::dwg_tag_t  tag1_q;
  // stage 2
  logic signed [32:0] px2_d, py2_d, px2_q, py2_q;
  logic signed [34:0] pc2_d, pc2_q;
  logic signed [33:0] pd2_d, pd2_q;
  logic signed [15:0] c2_q, old2_q;
  dwg_pkg::dwg_tag_t  tag2_q;
  // stage 3
  logic signed [35:0] sum3_d, sum3_q;
  logic signed [33:0] rd3;
  logic signed [15:0] dv3_d, dv3_q, c3_q;
  dwg_pkg::dwg_tag_t  tag3_q;
  // stage 4
  logic signed [53:0] prod4_d, prod4_q;
  logic signed [15:0] dv4_q, c4_q;
  dwg_pkg::dwg_tag_t  tag4_q;
  // stage 5
  logic signed [53:0] rn5;
  logic signed [15:0] nv5;
  dwg_pkg::dwg_out_t  res_d, res_q;

  assign px2_d = ns1_q * $signed({1'b0, coef_i.coef_x});
  assign py2_d = we1_q * $signed({1'b0, coef_i.coef_y});
  assign pc2_d = c1_q * $signed({1'b0, coef_i.coef_centre});
  assign pd2_d = c1_q * $signed({1'b0, coef_i.damping});

  assign sum3_d = 36'(px2_q) + 36'(py2_q) + 36'(pc2_q) - (36'(old2_q) <<< 16);
  // round half up: add half, then floor shift
  assign rd3    = pd2_q + 34'sd32768;
  assign dv3_d  = dwg_pkg::sat16(32'(rd3 >>> 16));

  assign prod4_d = sum3_q * $signed({1'b0, coef_i.damping});

  assign rn5 = prod4_q + 54'sd2147483648;
  assign nv5 = dwg_pkg::sat16(32'(rn5 >>> 32));

  always_comb begin
    res_d.new_value     = (tag4_q.interior && !tag4_q.land) ? nv5 : '0;
    res_d.damped_value  = tag4_q.interior ? dv4_q : c4_q;
    res_d.row           = tag4_q.row;
    res_d.col           = tag4_q.col;
    res_d.last_of_frame = tag4_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[3:0], job_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ns1_q   <= 17'(job_i.above) + 17'(job_i.below);
      we1_q   <= 17'(job_i.left) + 17'(job_i.right);
      c1_q    <= job_i.centre;
      old1_q  <= job_i.old;
      tag1_q  <= job_i.tag;

      px2_q   <= px2_d;
      py2_q   <= py2_d;
      pc2_q   <= pc2_d;
      pd2_q   <= pd2_d;
      c2_q    <= c1_q;
      old2_q  <= old1_q;
      tag2_q  <= tag1_q;

      sum3_q  <= sum3_d;
      dv3_q   <= dv3_d;
      c3_q    <= c2_q;
      tag3_q  <= tag2_q;

      prod4_q <= prod4_d;
      dv4_q   <= dv3_q;
      c4_q    <= c3_q;
      tag4_q  <= tag3_q;

      res_q   <= res_d;
    end
  end

  assign res_valid_o = v_q[4];
  assign res_o       = res_q;

endmodule

### rtl/damped_wave_grid_step.sv
// Damped 2-D wave leapfrog step over a raster-order cell stream.
// Throughput: one word per cycle; the whole pipeline freezes while the output word stalls.
// Results: a cell's result is formed once the word one row plus one cell later
// is accepted (grid_cols + 1 words behind it), then passes the 5-stage arithmetic pipeline.
// Reset: coefficients and grid size return to defaults, counters clear; row delays
// are undefined until filled, with no clearing pass. Depends on dwg_pkg, dwg_line, dwg_math.
module damped_wave_grid_step #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 128
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  dwg_pkg::dwg_in_t                    in_word_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output dwg_pkg::dwg_out_t                   out_word_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dwg_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [dwg_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int MaxDim = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
  localparam int DimLog = $clog2(MaxDim + 2);
  localparam int DimW   = (DimLog > 9) ? DimLog : 9;

  // configuration
  dwg_pkg::dwg_coef_t coef_q;
  logic [7:0]         grid_cols_q, grid_rows_q;

  // frame position
  logic [DimW-1:0] seen_q, row_q, col_q;
  logic [DimW-1:0] seen_b, row_b, col_b, row_c, col_c;
  logic [DimW-1:0] seen_n, row_n, col_n, col_inc;
  logic [DimW-1:0] cols, rows, cols_ext, rows_ext, start;
  logic            emit, interior, last;

  logic adv, in_acc;

  // row delay A words: {land, old, cur}; the left and row-B words hold cur only
  logic [32:0] in_ld, r1_q, a_out, ctr_q;
  logic [15:0] lft_q, b_out;

  dwg_pkg::dwg_job_t job;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.coef_x      <= dwg_pkg::COEF_X_RST;
      coef_q.coef_y      <= dwg_pkg::COEF_Y_RST;
      coef_q.coef_centre <= dwg_pkg::COEF_CENTRE_RST;
      coef_q.damping     <= dwg_pkg::DAMPING_RST;
      grid_cols_q        <= dwg_pkg::GRID_COLS_RST;
      grid_rows_q        <= dwg_pkg::GRID_ROWS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        dwg_pkg::REG_COEF_X:      coef_q.coef_x      <= cfg_data_i[14:0];
        dwg_pkg::REG_COEF_Y:      coef_q.coef_y      <= cfg_data_i[14:0];
        dwg_pkg::REG_COEF_CENTRE: coef_q.coef_centre <= cfg_data_i[17:0];
        dwg_pkg::REG_DAMPING:     coef_q.damping     <= cfg_data_i[16:0];
        dwg_pkg::REG_GRID_COLS:   grid_cols_q        <= cfg_data_i[7:0];
        dwg_pkg::REG_GRID_ROWS:   grid_rows_q        <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // clamp geometry to [3, MAX]
  assign cols_ext = DimW'(grid_cols_q);
  assign rows_ext = DimW'(grid_rows_q);
  assign cols = (cols_ext < DimW'(dwg_pkg::MIN_DIM)) ? DimW'(dwg_pkg::MIN_DIM) :
                (cols_ext > DimW'(MAX_COLS)) ? DimW'(MAX_COLS) : cols_ext;
  assign rows = (rows_ext < DimW'(dwg_pkg::MIN_DIM)) ? DimW'(dwg_pkg::MIN_DIM) :
                (rows_ext > DimW'(MAX_ROWS)) ? DimW'(MAX_ROWS) : rows_ext;
  assign start = DimW'(MAX_COLS) - cols;

  // stall the input only while the output word waits
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    seen_b = in_word_i.frame_first ? '0 : seen_q;
    row_b  = in_word_i.frame_first ? '0 : row_q;
    col_b  = in_word_i.frame_first ? '0 : col_q;
    if (col_b >= cols) begin
      col_c = '0;
      row_c = row_b + DimW'(1);
    end else begin
      col_c = col_b;
      row_c = row_b;
    end

    emit     = (seen_b >= cols + DimW'(1)) && (row_c < rows);
    interior = (row_c >= DimW'(1)) && (row_c + DimW'(1) < rows) &&
               (col_c >= DimW'(1)) && (col_c + DimW'(1) < cols);
    last     = (row_c + DimW'(1) == rows) && (col_c + DimW'(1) == cols);

    col_inc = col_c + DimW'(1);
    seen_n  = seen_b;
    row_n   = row_c;
    col_n   = col_c;
    if (emit) begin
      if (col_inc >= cols) begin
        col_n = '0;
        row_n = row_c + DimW'(1);
      end else begin
        col_n = col_inc;
      end
    end else if (seen_b < cols + DimW'(1)) begin
      seen_n = seen_b + DimW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      row_q  <= '0;
      col_q  <= '0;
    end else if (in_acc) begin
      seen_q <= seen_n;
      row_q  <= row_n;
      col_q  <= col_n;
    end
  end

  // flush words enter as zero water cells
  assign in_ld = in_word_i.is_flush ? '0 :
                 {in_word_i.is_land, in_word_i.old_value, in_word_i.cur_value};

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      r1_q  <= in_ld;
      ctr_q <= a_out;
      lft_q <= ctr_q[15:0];
    end
  end

  // one cell behind -> cols behind
  dwg_line #(
    .W    (33),
    .DEPTH(MAX_COLS - 1),
    .SEL_W(DimW)
  ) u_line_a (
    .clk_i  (clk_i),
    .en_i   (in_acc),
    .start_i(start),
    .line_i (r1_q),
    .line_o (a_out)
  );

  // centre -> row above
  dwg_line #(
    .W    (16),
    .DEPTH(MAX_COLS),
    .SEL_W(DimW)
  ) u_line_b (
    .clk_i  (clk_i),
    .en_i   (in_acc),
    .start_i(start),
    .line_i (ctr_q[15:0]),
    .line_o (b_out)
  );

  always_comb begin
    job.above        = $signed(b_out);
    job.below        = $signed(r1_q[15:0]);
    job.left         = $signed(lft_q);
    job.right        = $signed(a_out[15:0]);
    job.centre       = $signed(ctr_q[15:0]);
    job.old          = $signed(ctr_q[31:16]);
    job.tag.land     = ctr_q[32];
    job.tag.interior = interior;
    job.tag.last     = last;
    job.tag.row      = row_c[6:0];
    job.tag.col      = col_c[6:0];
  end

  dwg_math u_math (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .job_valid_i(in_acc && emit),
    .job_i      (job),
    .coef_i     (coef_q),
    .res_valid_o(out_valid_o),
    .res_o      (out_word_o)
  );

  a_stall_only_on_held_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held output word");

  a_frame_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_word_i.frame_first) |=>
      (seen_q == DimW'(1) && row_q == '0 && col_q == '0))
    else $error("frame start did not restart the position counters");

  a_seen_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= DimW'(MAX_COLS + 1))
    else $error("item count ran past one row plus one cell");

  a_col_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && emit) |=> ((col_q == $past(col_c) + DimW'(1)) || (col_q == '0)))
    else $error("column did not advance by one after a result");

endmodule
